>>> sv/dps_pkg.sv
// Shared types and constants of the dynamic priority scheduler.
package dps_pkg;

   // Result status codes.
   localparam logic [2:0] ST_ADDED    = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_WAITS    = 3'd2;
   localparam logic [2:0] ST_FINISHED = 3'd3;
   localparam logic [2:0] ST_IDLE_TCK = 3'd4;

   // Input actions.
   localparam logic ACT_ADD  = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   // Cell commands.
   localparam logic [1:0] CMD_HOLD   = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_POP    = 2'd2;

   // Register index of priority_step (byte address divided by four).
   localparam logic CSR_STEP_IDX = 1'b0;
   localparam logic [7:0] STEP_RESET = 8'd3;

   localparam int READY_W = 5;

   typedef struct packed {
      logic        valid;
      logic [7:0]  id;
      logic [15:0] prio;    // two's complement priority
      logic [15:0] ticks;   // run time still needed
   } entry_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       prev_keep;  // left neighbor keeps its place on insertion
      entry_type  new_entry;  // entry being inserted
   } cell_ctl_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [7:0]         ran_id;
      logic [15:0]        new_prio;
      logic [15:0]        rem;
      logic [READY_W-1:0] ready;
   } result_type;

endpackage

>>> sv/dps_cell.sv
// One slot of the sorted ready table; shifts toward its neighbors on insert and pop.
module dps_cell
   import dps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  entry_type    prev_entry,
   input  entry_type    next_entry,
   output entry_type    cur_entry,
   output logic         keep
);

   logic      valid_ff, valid_in;
   entry_type data_ff, data_in;

   // The slot keeps its entry when that entry outranks the new one.
   assign keep = valid_ff && ($signed(data_ff.prio) > $signed(ctl.new_entry.prio));

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      case (ctl.cmd)
         CMD_INSERT: begin
            if (!keep) begin
               if (ctl.prev_keep) begin
                  data_in  = ctl.new_entry;
                  valid_in = 1'b1;
               end else begin
                  data_in  = prev_entry;
                  valid_in = prev_entry.valid;
               end
            end
         end
         CMD_POP: begin
            data_in  = next_entry;
            valid_in = next_entry.valid;
         end
         default: begin
            data_in  = data_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      cur_entry       = data_ff;
      cur_entry.valid = valid_ff;
   end

endmodule

>>> sv/dynamic_priority_scheduler.sv
// Top level of the dynamic priority scheduler: cell chain, sequencer, result queue, CSR.
//
//   Channel   Direction  Handshake            Payload
//   req       in         req_valid/req_stall  action, proc_id, priority_req, run_ticks
//   rsp       out        rsp_valid/rsp_stall  status, ran_id, new_priority,
//                                             remaining_time, ready_count
//   csr       in         APB (psel/penable)   priority_step at byte address 0
//
// On an add the new entry is broadcast to the chain and every cell either keeps its entry,
// takes the new one, or takes its left neighbor's. A tick on an empty table only reports
// idle, and one whose run process finishes only shifts the chain left to remove the head;
// otherwise the head is removed likewise, then the run process is inserted again.
// Reset is synchronous; it empties the table and sets priority_step to 3.
// Results go through a two-entry queue, so one transfer may be accepted while an
// earlier result still waits; req_stall rises while the queue is full and while a tick
// reinserts its run process.
module dynamic_priority_scheduler
   import dps_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [7:0]         req_proc_id,
   input  logic signed [15:0] req_priority_req,
   input  logic [15:0]        req_run_ticks,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [7:0]         rsp_ran_id,
   output logic signed [15:0] rsp_new_priority,
   output logic [15:0]        rsp_remaining_time,
   output logic [4:0]         rsp_ready_count,
   // configuration port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

   // Sequencer states.
   localparam logic STATE_IDLE   = 1'b0;
   localparam logic STATE_REINS  = 1'b1;

   // ---------------------------------------------------------------------
   // Configuration register.
   // ---------------------------------------------------------------------
   logic [7:0] step_ff, step_in;
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      step_in = step_ff;
      if (csr_wr && (csr_paddr[2] == CSR_STEP_IDX)) begin
         step_in = csr_pwdata[7:0];
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == CSR_STEP_IDX) begin
         csr_prdata = {24'd0, step_ff};
      end
   end

   // ---------------------------------------------------------------------
   // Control state.
   // ---------------------------------------------------------------------
   logic          state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   entry_type     pend_ff, pend_in;
   logic [1:0]    ocnt_ff, ocnt_in;
   result_type    out0_ff, out0_in, out1_ff, out1_in;

   logic       accept, push, pop;
   result_type push_data;

   assign req_stall = (state_ff != STATE_IDLE) || (ocnt_ff == 2'd2);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (ocnt_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;

   // ---------------------------------------------------------------------
   // Cell chain.
   // ---------------------------------------------------------------------
   entry_type cur   [QUEUE_DEPTH];
   logic      keep  [QUEUE_DEPTH];
   logic [1:0] cmd;
   entry_type  new_entry;

   always_comb begin
      new_entry.valid = 1'b1;
      new_entry.id    = req_proc_id;
      new_entry.prio  = req_priority_req;
      new_entry.ticks = req_run_ticks;
      if (state_ff == STATE_REINS) begin
         new_entry = pend_ff;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         cell_ctl_type ctl;
         entry_type    prev_e, next_e;

         if (gi == 0) begin : g_first
            assign prev_e        = '0;
            assign ctl.prev_keep = 1'b1;
         end else begin : g_mid
            assign prev_e        = cur[gi-1];
            assign ctl.prev_keep = keep[gi-1];
         end
         if (gi == QUEUE_DEPTH - 1) begin : g_last
            assign next_e = '0;
         end else begin : g_inner
            assign next_e = cur[gi+1];
         end
         assign ctl.cmd       = cmd;
         assign ctl.new_entry = new_entry;

         dps_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .cur_entry  (cur[gi]),
            .keep       (keep[gi])
         );
      end
   endgenerate

   // ---------------------------------------------------------------------
   // Run step of the head process.
   // ---------------------------------------------------------------------
   logic signed [16:0] diff;
   logic [15:0]        run_prio, run_rem;

   assign diff = $signed({cur[0].prio[15], cur[0].prio}) - $signed({9'd0, step_ff});

   always_comb begin
      run_prio = diff[15:0];
      // A result below the signed floor sticks at the floor.
      if (diff[16] && !diff[15]) begin
         run_prio = 16'h8000;
      end
      run_rem = (cur[0].ticks == 16'd0) ? 16'd0 : (cur[0].ticks - 16'd1);
   end

   // ---------------------------------------------------------------------
   // Sequencer.
   // ---------------------------------------------------------------------
   logic [31:0] cnt_now, cnt_up, cnt_dn;

   assign cnt_now = 32'(cnt_ff);
   assign cnt_up  = 32'(cnt_ff) + 32'd1;
   assign cnt_dn  = 32'(cnt_ff) - 32'd1;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pend_in   = pend_ff;
      cmd       = CMD_HOLD;
      push      = 1'b0;
      push_data = '0;

      case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               push = 1'b1;
               if (req_action == ACT_ADD) begin
                  if (cnt_ff == DEPTH_CNT) begin
                     push_data.status = ST_FULL;
                     push_data.ready  = cnt_now[READY_W-1:0];
                  end else begin
                     cmd              = CMD_INSERT;
                     cnt_in           = cnt_ff + CW'(1);
                     push_data.status = ST_ADDED;
                     push_data.ready  = cnt_up[READY_W-1:0];
                  end
               end else if (cnt_ff == '0) begin
                  push_data.status = ST_IDLE_TCK;
               end else begin
                  cmd           = CMD_POP;
                  cnt_in        = cnt_ff - CW'(1);
                  pend_in.valid = 1'b1;
                  pend_in.id    = cur[0].id;
                  pend_in.prio  = run_prio;
                  pend_in.ticks = run_rem;
                  if (run_rem == 16'd0) begin
                     push_data.status   = ST_FINISHED;
                     push_data.ran_id   = cur[0].id;
                     push_data.new_prio = run_prio;
                     push_data.ready    = cnt_dn[READY_W-1:0];
                  end else begin
                     // The process still needs time: put it back next cycle.
                     push     = 1'b0;
                     state_in = STATE_REINS;
                  end
               end
            end
         end
         STATE_REINS: begin
            cmd                = CMD_INSERT;
            cnt_in             = cnt_ff + CW'(1);
            push               = 1'b1;
            push_data.status   = ST_WAITS;
            push_data.ran_id   = pend_ff.id;
            push_data.new_prio = pend_ff.prio;
            push_data.rem      = pend_ff.ticks;
            push_data.ready    = cnt_up[READY_W-1:0];
            state_in           = STATE_IDLE;
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Two-entry result queue; out0 is the head shown on the rsp ports.
   // ---------------------------------------------------------------------
   always_comb begin
      ocnt_in = ocnt_ff;
      out0_in = out0_ff;
      out1_in = out1_ff;
      if (push && pop) begin
         if (ocnt_ff == 2'd1) begin
            out0_in = push_data;
         end else begin
            out0_in = out1_ff;
            out1_in = push_data;
         end
      end else if (push) begin
         ocnt_in = ocnt_ff + 2'd1;
         if (ocnt_ff == 2'd0) begin
            out0_in = push_data;
         end else begin
            out1_in = push_data;
         end
      end else if (pop) begin
         ocnt_in = ocnt_ff - 2'd1;
         out0_in = out1_ff;
      end
   end

   assign rsp_status         = out0_ff.status;
   assign rsp_ran_id         = out0_ff.ran_id;
   assign rsp_new_priority   = out0_ff.new_prio;
   assign rsp_remaining_time = out0_ff.rem;
   assign rsp_ready_count    = out0_ff.ready;

   // ---------------------------------------------------------------------
   // Registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
         cnt_ff   <= '0;
         ocnt_ff  <= 2'd0;
         step_ff  <= STEP_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ocnt_ff  <= ocnt_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      out0_ff <= out0_in;
      out1_ff <= out1_in;
   end

`ifndef SYNTHESIS
   // The table never holds more processes than it has cells.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DEPTH_CNT)
      else $error("ready count exceeds table depth");

   // The head cell holds a process exactly when the table is not empty.
   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) == cur[0].valid)
      else $error("head cell validity disagrees with count");

   // A reinsertion always follows a tick that left the process waiting.
   a_reins_origin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_REINS) |-> $past(accept && (req_action == ACT_TICK)))
      else $error("reinsertion without a preceding tick");

   // A pushed result always finds room in the queue.
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      push |-> ((ocnt_ff != 2'd2) || pop))
      else $error("result queue overflow");
`endif

endmodule

>>> verif/dynamic_priority_scheduler_tb.sv
// Self-checking testbench of the dynamic priority scheduler: directed table, then random traffic.
module dynamic_priority_scheduler_tb;
   import dps_pkg::*;

   // The table depth of the block under test. The predictor below keeps a table of the same depth.
   localparam int DEPTH = 16;

   // CSR byte addresses. Address 0 holds priority_step. Address 4 holds no register, so a
   // write there must leave the step alone.
   localparam logic [2:0] CSR_STEP_ADDR  = 3'd0;
   localparam logic [2:0] CSR_SPARE_ADDR = 3'd4;

   // The run stops with a failure if it is still going when cycle_count reaches CYCLE_LIMIT.
   localparam int CYCLE_LIMIT = 400000;

   // This is how long the receiver holds off once, so that the result queue fills up and the
   // block stalls its input.
   localparam int LONG_HOLD = 120;

   localparam int RANDOM_PHASES    = 4;
   localparam int ITEMS_PER_PHASE  = 106;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_action = ACT_ADD;
   logic [7:0]         req_proc_id = '0;
   logic signed [15:0] req_priority_req = '0;
   logic [15:0]        req_run_ticks = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_status;
   logic [7:0]         rsp_ran_id;
   logic signed [15:0] rsp_new_priority;
   logic [15:0]        rsp_remaining_time;
   logic [4:0]         rsp_ready_count;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [2:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   dynamic_priority_scheduler #(
      .QUEUE_DEPTH(DEPTH)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_proc_id        (req_proc_id),
      .req_priority_req   (req_priority_req),
      .req_run_ticks      (req_run_ticks),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_ran_id         (rsp_ran_id),
      .rsp_new_priority   (rsp_new_priority),
      .rsp_remaining_time (rsp_remaining_time),
      .rsp_ready_count    (rsp_ready_count),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // This is the predicted ready table. Slot 0 is the head, and slots [0, ready_total) are
   // occupied. Priorities are kept as int so that the step subtraction can be clamped at the
   // floor.
   logic [7:0]  ready_id   [DEPTH];
   int          ready_prio [DEPTH];
   logic [15:0] ready_time [DEPTH];
   int          ready_total = 0;
   logic [7:0]  step_reg = STEP_RESET;

   // These are the results the block owes, in order of the transfers that caused them.
   result_type pending_results[$];

   int mismatches = 0;
   int results_seen = 0;
   int cycle_count = 0;
   int burst_left = 0;
   bit long_hold_done = 1'b0;

   // One row of the directed table. A configuration row writes a CSR once the block has drained.
   // An operation row is sent rep times with the id counting up. A typed row carries its own
   // expected result; the others take the predictor's.
   typedef struct {
      bit                 is_cfg;
      logic [2:0]         cfg_addr;
      logic [31:0]        cfg_data;
      logic               action;
      logic [7:0]         id;
      logic signed [15:0] prio;
      logic [15:0]        need;
      int                 rep;
      bit                 typed;
      result_type         want;
   } stim_row_type;

   stim_row_type directed_rows[$];

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // This puts a process ahead of every entry whose priority is equal to or lower than its own.
   function automatic void insert_ready(logic [7:0] id, int prio, logic [15:0] ticks);
      int pos;
      pos = 0;
      while (pos < ready_total && ready_prio[pos] > prio) pos++;
      for (int k = ready_total; k > pos; k--) begin
         ready_id[k]   = ready_id[k-1];
         ready_prio[k] = ready_prio[k-1];
         ready_time[k] = ready_time[k-1];
      end
      ready_id[pos]   = id;
      ready_prio[pos] = prio;
      ready_time[pos] = ticks;
      ready_total++;
   endfunction

   // This advances the predicted table by one accepted item and returns the result it must
   // produce.
   function automatic result_type schedule_result(logic action, logic [7:0] id,
                                                  logic signed [15:0] prio, logic [15:0] need);
      result_type  r;
      int          lowered;
      logic [15:0] left;
      logic [7:0]  head_id;
      r = '0;
      if (action == ACT_ADD) begin
         if (ready_total >= DEPTH) begin
            r.status = ST_FULL;
         end else begin
            insert_ready(id, int'(prio), need);
            r.status = ST_ADDED;
         end
      end else if (ready_total == 0) begin
         r.status = ST_IDLE_TCK;
      end else begin
         head_id = ready_id[0];
         lowered = ready_prio[0] - int'(step_reg);
         if (lowered < -32768) lowered = -32768;
         // A process added with no run time stays at zero instead of wrapping.
         left = ready_time[0];
         if (left != 0) left--;
         for (int k = 1; k < ready_total; k++) begin
            ready_id[k-1]   = ready_id[k];
            ready_prio[k-1] = ready_prio[k];
            ready_time[k-1] = ready_time[k];
         end
         ready_total--;
         r.ran_id   = head_id;
         r.new_prio = lowered[15:0];
         r.rem      = left;
         if (left == 0) begin
            r.status = ST_FINISHED;
         end else begin
            insert_ready(head_id, lowered, left);
            r.status = ST_WAITS;
         end
      end
      r.ready = ready_total[READY_W-1:0];
      return r;
   endfunction

   function automatic void op_row(logic action, logic [7:0] id, logic signed [15:0] prio,
                                  logic [15:0] need, int rep, bit typed, logic [2:0] st,
                                  logic [7:0] ran, logic signed [15:0] np, logic [15:0] rem,
                                  logic [4:0] rdy);
      stim_row_type row;
      row = '{default: '0};
      row.action = action;
      row.id     = id;
      row.prio   = prio;
      row.need   = need;
      row.rep    = rep;
      row.typed  = typed;
      row.want   = '{status: st, ran_id: ran, new_prio: np, rem: rem, ready: rdy};
      directed_rows.push_back(row);
   endfunction

   function automatic void cfg_row(logic [2:0] addr, logic [31:0] data);
      stim_row_type row;
      row = '{default: '0};
      row.is_cfg   = 1'b1;
      row.cfg_addr = addr;
      row.cfg_data = data;
      directed_rows.push_back(row);
   endfunction

   // Most idle stretches are short, and a few are long.
   function automatic int pick_idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // The priorities cluster around a few values so that equal-priority ordering comes up often.
   // The rest are full range, the extremes, or values near the floor.
   function automatic logic signed [15:0] random_prio();
      int v;
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 65535));
         1: begin
            v = $urandom_range(0, 4);
            return 16'(v - 2);
         end
         2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         default: return 16'(-32768 + int'($urandom_range(0, 300)));
      endcase
   endfunction

   // Most run times are short so that processes retire and the table keeps turning over.
   function automatic logic [15:0] random_need();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return 16'($urandom_range(1, 4));
      if (r < 9) return 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 2))
         0: return 16'd0;
         1: return 16'd1;
         default: return 16'hFFFF;
      endcase
   endfunction

   // This offers one item and returns at the edge where the transfer happens. req_valid stays
   // high afterward, so the next item can follow back to back without a second assignment in
   // the same step.
   task automatic send_item(logic action, logic [7:0] id, logic signed [15:0] prio,
                            logic [15:0] need, bit typed, result_type want);
      int gap;
      result_type predicted;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         gap = pick_idle_len();
         if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 30);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= action;
      req_proc_id      <= id;
      req_priority_req <= prio;
      req_run_ticks    <= need;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = schedule_result(action, id, prio, need);
      pending_results.push_back(typed ? want : predicted);
   endtask

   // Every item produces a result, so the block is idle once nothing is owed any more.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // This does an APB write followed by a read-back of priority_step. Only address bit 2
   // selects a register. Data bits above the eighth are dropped by the register.
   task automatic write_csr(logic [2:0] addr, logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      if (addr[2] == CSR_STEP_IDX) step_reg = data[7:0];
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_STEP_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      check_field("prdata", {24'd0, step_reg}, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // This is the directed table. It runs with the reset step of 3.
   initial begin
      // A tick on an empty table reports idle, and every field is zero.
      op_row(ACT_TICK, 8'h00, 16'sd0, 16'd0, 1, 1'b1, ST_IDLE_TCK, 8'h00, 16'sd0, 16'd0, 5'd0);
      // A process at the lowest priority runs once. Its priority stays clamped at the floor.
      op_row(ACT_ADD, 8'h00, 16'sh8000, 16'd1, 1, 1'b1, ST_ADDED, 8'h00, 16'sd0, 16'd0, 5'd1);
      op_row(ACT_TICK, 8'h00, 16'sd0, 16'd0, 1, 1'b1,
             ST_FINISHED, 8'h00, 16'sh8000, 16'd0, 5'd0);
      // These are the highest priority and the longest run time. The second add has equal
      // priority, so it goes ahead of the first.
      op_row(ACT_ADD, 8'hFF, 16'sh7FFF, 16'hFFFF, 1, 1'b1, ST_ADDED, 8'h00, 16'sd0, 16'd0, 5'd1);
      op_row(ACT_ADD, 8'h11, 16'sh7FFF, 16'd2, 1, 1'b1, ST_ADDED, 8'h00, 16'sd0, 16'd0, 5'd2);
      op_row(ACT_TICK, 8'h00, 16'sd0, 16'd0, 1, 1'b1,
             ST_WAITS, 8'h11, 16'sd32764, 16'd1, 5'd2);
      op_row(ACT_TICK, 8'h00, 16'sd0, 16'd0, 2, 1'b0, '0, '0, '0, '0, '0);
      // A process added with no run time finishes at its first tick, and its time does not
      // wrap.
      op_row(ACT_ADD, 8'h22, 16'sh7FFF, 16'd0, 1, 1'b0, '0, '0, '0, '0, '0);
      op_row(ACT_TICK, 8'h00, 16'sd0, 16'd0, 1, 1'b1,
             ST_FINISHED, 8'h22, 16'sd32764, 16'd0, 5'd2);
      // These rows fill the table with equal priorities. One more add is then turned away.
      op_row(ACT_ADD, 8'h40, 16'sd0, 16'd3, 14, 1'b0, '0, '0, '0, '0, '0);
      op_row(ACT_ADD, 8'h80, 16'sd5, 16'd9, 1, 1'b1, ST_FULL, 8'h00, 16'sd0, 16'd0, 5'd16);
      // This is the largest step, with junk in the upper data bits. A write to an address that
      // holds no register follows; it must be ignored.
      cfg_row(CSR_STEP_ADDR, 32'hABCD_EFFF);
      cfg_row(CSR_SPARE_ADDR, 32'h0000_0055);
   end

   // This is the receiver. It alternates stretches with rsp_stall low and random stalls. Once,
   // early in the random traffic, it holds off for the LONG_HOLD stretch while the sender keeps
   // offering, so the block's queue fills and req_stall must rise.
   initial begin
      int open_len;
      int stall_len;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         rsp_stall <= 1'b0;
         open_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
         repeat (open_len) @(posedge clock);
         stall_len = pick_idle_len();
         if (!long_hold_done && results_seen >= 60) begin
            long_hold_done = 1'b1;
            stall_len = LONG_HOLD;
         end
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
         end
      end
   end

   // Each result transfer is matched against the oldest result still owed.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("result transfer with no result owed: status %0h id %0h",
                   rsp_status, rsp_ran_id);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("ran_id", want.ran_id, rsp_ran_id);
            check_field("new_priority", want.new_prio, $unsigned(rsp_new_priority));
            check_field("remaining_time", want.rem, rsp_remaining_time);
            check_field("ready_count", want.ready, rsp_ready_count);
         end
      end
   end

   // This is a watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // The main sequence is reset, the directed table, then random phases. Every phase but the
   // first starts with a fresh step written while the block is idle.
   initial begin
      stim_row_type row;
      int           add_pct;
      logic         action;
      logic [31:0]  step_word;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_cfg) begin
            wait_drained();
            write_csr(row.cfg_addr, row.cfg_data);
         end else begin
            for (int k = 0; k < row.rep; k++)
               send_item(row.action, row.id + 8'(k), row.prio, row.need, row.typed, row.want);
         end
      end

      // The random traffic starts on a full table with the largest step. Later phases use no
      // step at all, a random step, and then the reset value again. The mix of adds and ticks
      // shifts so that the table both drains to empty and fills up.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p > 0) begin
            case (p)
               1:       step_word = 32'h0000_0000;
               2:       step_word = $urandom;
               default: step_word = {24'hFFFFFF, STEP_RESET};
            endcase
            wait_drained();
            write_csr(CSR_STEP_ADDR, step_word);
         end
         case (p)
            1:       add_pct = 30;
            2:       add_pct = 70;
            default: add_pct = 50;
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            action = ($urandom_range(0, 99) < add_pct) ? ACT_ADD : ACT_TICK;
            send_item(action, 8'($urandom_range(0, 255)), random_prio(), random_need(),
                      1'b0, '0);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d results still owed at the end", pending_results.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
